// ----- hw/rtl/sm3_pkg.sv -----
package sm3_pkg;

    localparam int WordW    = 32;
    localparam int ChainLen = 8;
    localparam int BlockLen = 16;
    localparam int Rounds   = 64;

    localparam logic [WordW-1:0] T_LOW    = 32'h79cc4519;
    localparam logic [WordW-1:0] T_HIGH   = 32'h7a879d8a;
    localparam logic [WordW-1:0] PAD_WORD = 32'h80000000;
    localparam logic [7:0]       PAD_BYTE = 8'h80;

    typedef logic [ChainLen-1:0][WordW-1:0] chain_t;

    localparam chain_t SM3_IV = {
        32'hb0fb0e4e, 32'he38dee4d, 32'h163138aa, 32'ha96f30bc,
        32'hda8a0600, 32'h172442d7, 32'h4914b2b9, 32'h7380166f
    };

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PAD,
        ST_COMP,
        ST_OUT
    } state_t;

    // Requests from the sequencer to the compression unit.
    typedef struct packed {
        logic             push;
        logic [WordW-1:0] word;
        logic             start;
        logic             iv_load;
    } cmp_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } cmp_stat_t;

    function automatic logic [WordW-1:0] rotl32(input logic [WordW-1:0] x, input int n);
        logic [2*WordW-1:0] d;
        d = {x, x} << (n % WordW);
        return d[2*WordW-1:WordW];
    endfunction

    function automatic logic [WordW-1:0] perm0(input logic [WordW-1:0] x);
        return x ^ rotl32(x, 9) ^ rotl32(x, 17);
    endfunction

    function automatic logic [WordW-1:0] perm1(input logic [WordW-1:0] x);
        return x ^ rotl32(x, 15) ^ rotl32(x, 23);
    endfunction

endpackage

// ----- hw/rtl/sm3_compress.sv -----
module sm3_compress
    import sm3_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  cmp_ctrl_t ctrl,
    output cmp_stat_t stat,
    output chain_t    chain
);

    logic [BlockLen-1:0][WordW-1:0] win_reg;
    logic [ChainLen-1:0][WordW-1:0] v_reg, v_next;
    chain_t                         chain_reg;
    logic [WordW-1:0]               t_reg;
    logic [5:0]                     round_reg;
    logic                           busy_reg;

    logic [WordW-1:0] a12, ss1, ss2, ff, gg, tt1, tt2, w_new;
    logic             early;
    logic             last_round;

    assign early      = (round_reg[5:4] == 2'd0);
    assign last_round = busy_reg && (round_reg == 6'(Rounds - 1));

    // One SM3 round: the window head is w[j], four ahead is w[j+4].
    always_comb begin
        a12 = rotl32(v_reg[0], 12);
        ss1 = rotl32(a12 + v_reg[4] + t_reg, 7);
        ss2 = ss1 ^ a12;
        if (early) begin
            ff = v_reg[0] ^ v_reg[1] ^ v_reg[2];
            gg = v_reg[4] ^ v_reg[5] ^ v_reg[6];
        end else begin
            ff = (v_reg[0] & v_reg[1]) | (v_reg[0] & v_reg[2]) | (v_reg[1] & v_reg[2]);
            gg = (v_reg[4] & v_reg[5]) | (~v_reg[4] & v_reg[6]);
        end
        tt1 = ff + v_reg[3] + ss2 + (win_reg[0] ^ win_reg[4]);
        tt2 = gg + v_reg[7] + ss1 + win_reg[0];
        v_next[0] = tt1;
        v_next[1] = v_reg[0];
        v_next[2] = rotl32(v_reg[1], 9);
        v_next[3] = v_reg[2];
        v_next[4] = perm0(tt2);
        v_next[5] = v_reg[4];
        v_next[6] = rotl32(v_reg[5], 19);
        v_next[7] = v_reg[6];
        w_new = perm1(win_reg[0] ^ win_reg[7] ^ rotl32(win_reg[13], 15))
                ^ rotl32(win_reg[3], 7) ^ win_reg[10];
    end

    // The block buffer doubles as the message expansion window.
    always_ff @(posedge aclk) begin
        if (ctrl.push) begin
            win_reg <= {ctrl.word, win_reg[BlockLen-1:1]};
        end else if (busy_reg) begin
            win_reg <= {w_new, win_reg[BlockLen-1:1]};
        end
        if (ctrl.start) begin
            v_reg <= chain_reg;
        end else if (busy_reg) begin
            v_reg <= v_next;
        end
        if (ctrl.start) begin
            t_reg <= T_LOW;
        end else if (round_reg == 6'd15) begin
            t_reg <= rotl32(T_HIGH, 16);
        end else begin
            t_reg <= rotl32(t_reg, 1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chain_reg <= SM3_IV;
            round_reg <= '0;
            busy_reg  <= 1'b0;
        end else begin
            if (ctrl.iv_load) begin
                chain_reg <= SM3_IV;
            end else if (last_round) begin
                chain_reg <= chain_reg ^ v_next;
            end
            if (ctrl.start) begin
                round_reg <= '0;
                busy_reg  <= 1'b1;
            end else if (busy_reg) begin
                round_reg <= round_reg + 6'd1;
                if (last_round) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = last_round;
    assign chain     = chain_reg;

    rnd_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.start |-> !busy_reg)
        else $error("compression started while a block is in flight");

    rnd_no_push_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> !ctrl.push)
        else $error("word pushed during compression");

    rnd_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        last_round |=> !busy_reg && round_reg == '0)
        else $error("round counter did not wrap after the final round");

endmodule

// ----- hw/rtl/sm3_hash_engine_top.sv -----
// SM3 hash engine. Message words stream in big-endian on the s_ side, one
// beat per word; the beat with s_tlast set carries 0 to 4 leading valid bytes
// in s_tuser and starts padding. Each word is accepted while idle, except that
// the sixteenth word of a block starts a compression, one round per cycle
// in a single shared round unit, during which s_tready is low. After the last
// word the padding words go in one per cycle while no compression runs (up to
// 18 of them, running one extra compression when the length does not fit),
// then the eight digest words A..H leave on the m_ side, m_tlast on H. A
// message's tail adds 2 to 18 pad words, one or two compressions and 8 output
// beats. The engine is then ready with the initial value reloaded.
module sm3_hash_engine_top
    import sm3_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,  // msg_word[31:0]
    input  logic [2:0]  s_tuser,  // valid_bytes[2:0]
    input  logic        s_tlast,  // last_word
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,  // digest_word[31:0]
    output logic        m_tlast   // digest_last
);

    state_t      state_reg, state_next;
    logic [3:0]  fill_reg, fill_next;
    logic [63:0] len_reg, len_next;
    logic        pend80_reg, pend80_next;
    logic        lenph_reg, lenph_next;
    logic        final_reg, final_next;
    logic        pad_reg, pad_next;
    logic [2:0]  idx_reg, idx_next;

    cmp_ctrl_t ctrl;
    cmp_stat_t stat;
    chain_t    chain;

    logic [2:0]       nbytes;
    logic [WordW-1:0] keep_mask, pad_bit;

    sm3_compress u_cmp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .stat    (stat),
        .chain   (chain)
    );

    always_comb begin
        nbytes = (s_tuser > 3'd4) ? 3'd4 : s_tuser;
        unique case (nbytes)
            3'd0:    begin keep_mask = 32'h00000000; pad_bit = {PAD_BYTE, 24'h0}; end
            3'd1:    begin keep_mask = 32'hff000000; pad_bit = {8'h0, PAD_BYTE, 16'h0}; end
            3'd2:    begin keep_mask = 32'hffff0000; pad_bit = {16'h0, PAD_BYTE, 8'h0}; end
            3'd3:    begin keep_mask = 32'hffffff00; pad_bit = {24'h0, PAD_BYTE}; end
            default: begin keep_mask = 32'hffffffff; pad_bit = 32'h0; end
        endcase
    end

    always_comb begin
        state_next   = state_reg;
        fill_next    = fill_reg;
        len_next     = len_reg;
        pend80_next  = pend80_reg;
        lenph_next   = lenph_reg;
        final_next   = final_reg;
        pad_next     = pad_reg;
        idx_next     = idx_reg;
        ctrl.push    = 1'b0;
        ctrl.word    = '0;
        ctrl.start   = 1'b0;
        ctrl.iv_load = 1'b0;
        s_tready     = 1'b0;
        m_tvalid     = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    ctrl.push = 1'b1;
                    if (!s_tlast) begin
                        ctrl.word = s_tdata;
                        len_next  = len_reg + 64'd32;
                    end else begin
                        len_next    = len_reg + {58'd0, nbytes, 3'd0};
                        ctrl.word   = (s_tdata & keep_mask) | pad_bit;
                        pend80_next = (nbytes == 3'd4);
                        pad_next    = 1'b1;
                        state_next  = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                ctrl.push = 1'b1;
                priority if (pend80_reg) begin
                    ctrl.word   = PAD_WORD;
                    pend80_next = 1'b0;
                end else if (lenph_reg) begin
                    ctrl.word  = len_reg[31:0];
                    lenph_next = 1'b0;
                    final_next = 1'b1;
                end else if (fill_reg == 4'd14) begin
                    ctrl.word  = len_reg[63:32];
                    lenph_next = 1'b1;
                end else begin
                    ctrl.word = '0;
                end
            end
            ST_COMP: begin
                if (stat.done) begin
                    priority if (final_reg) begin
                        state_next = ST_OUT;
                    end else if (pad_reg) begin
                        state_next = ST_PAD;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_OUT: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'(ChainLen - 1)) begin
                        ctrl.iv_load = 1'b1;
                        len_next     = '0;
                        pad_next     = 1'b0;
                        final_next   = 1'b0;
                        state_next   = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // A word that completes the block hands over to the round unit.
        if (ctrl.push) begin
            fill_next = fill_reg + 4'd1;
            if (fill_reg == 4'(BlockLen - 1)) begin
                ctrl.start = 1'b1;
                state_next = ST_COMP;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            fill_reg   <= '0;
            len_reg    <= '0;
            pend80_reg <= 1'b0;
            lenph_reg  <= 1'b0;
            final_reg  <= 1'b0;
            pad_reg    <= 1'b0;
            idx_reg    <= '0;
        end else begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            len_reg    <= len_next;
            pend80_reg <= pend80_next;
            lenph_reg  <= lenph_next;
            final_reg  <= final_next;
            pad_reg    <= pad_next;
            idx_reg    <= idx_next;
        end
    end

    assign m_tdata = chain[idx_reg];
    assign m_tlast = (idx_reg == 3'(ChainLen - 1));

    top_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input and output open at once");

    top_out_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> fill_reg == '0 && !stat.busy)
        else $error("digest shown with a partial block");

    top_done_in_comp: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.done |-> state_reg == ST_COMP)
        else $error("round unit finished outside compression");

    top_back_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tlast |=> s_tready && len_reg == '0)
        else $error("engine not reset after the digest");

endmodule

// ----- test/tb.sv -----
module tb;

    localparam logic [31:0] PAD_MARK      = 32'h80000000;
    localparam logic [31:0] ROUND_T_EARLY = 32'h79cc4519;
    localparam logic [31:0] ROUND_T_LATE  = 32'h7a879d8a;
    localparam int          RANDOM_WORDS  = 300;
    localparam int          STALL_LIMIT   = 4000;
    localparam int          DRAIN_CYCLES  = 20;

    localparam logic [31:0] INIT_CHAIN [8] = '{
        32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
        32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e
    };

    typedef struct packed {
        logic [31:0] word;
        logic        last;
    } digest_beat_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic [2:0]  s_tuser  = '0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tlast;

    sm3_hash_engine_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // Shadow copy of the hash state.
    logic [31:0]  chain_words [8];
    logic [31:0]  block_words [16];
    int unsigned  block_fill;
    logic [63:0]  msg_bits;
    digest_beat_t digest_expected [$];

    int unsigned error_count    = 0;
    int unsigned words_sent     = 0;
    int unsigned messages_sent  = 0;
    int unsigned digests_seen   = 0;
    int unsigned extra_blocks   = 0;
    int unsigned burst_left     = 0;
    int unsigned ready_mode     = 0;
    int unsigned ready_left     = 0;
    int unsigned ready_phase    = 0;
    int unsigned idle_cycles    = 0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
        int unsigned k;
        k = n % 32;
        return (k == 0) ? x : ((x << k) | (x >> (32 - k)));
    endfunction

    function automatic logic [31:0] mix_state(input logic [31:0] x);
        return x ^ rotl(x, 9) ^ rotl(x, 17);
    endfunction

    function automatic logic [31:0] mix_schedule(input logic [31:0] x);
        return x ^ rotl(x, 15) ^ rotl(x, 23);
    endfunction

    function automatic void restart_hash();
        for (int i = 0; i < 8; i++) chain_words[i] = INIT_CHAIN[i];
        for (int i = 0; i < 16; i++) block_words[i] = '0;
        block_fill = 0;
        msg_bits   = '0;
    endfunction

    function automatic void compress_block();
        logic [31:0] w [68];
        logic [31:0] v [8];
        logic [31:0] tj, a12, ss1, ss2, ff, gg, tt1, tt2;
        for (int j = 0; j < 16; j++) w[j] = block_words[j];
        for (int j = 16; j < 68; j++)
            w[j] = mix_schedule(w[j-16] ^ w[j-9] ^ rotl(w[j-3], 15))
                   ^ rotl(w[j-13], 7) ^ w[j-6];
        for (int i = 0; i < 8; i++) v[i] = chain_words[i];
        for (int j = 0; j < 64; j++) begin
            tj  = rotl((j < 16) ? ROUND_T_EARLY : ROUND_T_LATE, j);
            a12 = rotl(v[0], 12);
            ss1 = rotl(a12 + v[4] + tj, 7);
            ss2 = ss1 ^ a12;
            if (j < 16) begin
                ff = v[0] ^ v[1] ^ v[2];
                gg = v[4] ^ v[5] ^ v[6];
            end else begin
                ff = (v[0] & v[1]) | (v[0] & v[2]) | (v[1] & v[2]);
                gg = (v[4] & v[5]) | (~v[4] & v[6]);
            end
            tt1  = ff + v[3] + ss2 + (w[j] ^ w[j+4]);
            tt2  = gg + v[7] + ss1 + w[j];
            v[3] = v[2];
            v[2] = rotl(v[1], 9);
            v[1] = v[0];
            v[0] = tt1;
            v[7] = v[6];
            v[6] = rotl(v[5], 19);
            v[5] = v[4];
            v[4] = mix_state(tt2);
        end
        for (int i = 0; i < 8; i++) chain_words[i] ^= v[i];
    endfunction

    function automatic void absorb_word(input logic [31:0] wd);
        block_words[block_fill] = wd;
        block_fill++;
        if (block_fill == 16) begin
            compress_block();
            block_fill = 0;
        end
    endfunction

    // Updates the shadow state for one accepted beat and queues the digest
    // when the beat closes a message.
    function automatic void predict_digest(input logic [31:0] wd, input logic [2:0] nbytes,
                                           input logic lst);
        int unsigned n;
        logic [31:0] keep;
        if (!lst) begin
            msg_bits += 64'd32;
            absorb_word(wd);
            return;
        end
        n = (nbytes > 3'd4) ? 4 : nbytes;
        msg_bits += 64'(8 * n);
        if (n == 4) begin
            absorb_word(wd);
            absorb_word(PAD_MARK);
        end else begin
            keep = ~(32'hffffffff >> (8 * n));
            absorb_word((wd & keep) | (PAD_MARK >> (8 * n)));
        end
        // No room left for the length: pad out and run one more block.
        if (block_fill > 14) begin
            extra_blocks++;
            while (block_fill != 0) absorb_word('0);
        end
        while (block_fill < 14) absorb_word('0);
        absorb_word(msg_bits[63:32]);
        absorb_word(msg_bits[31:0]);
        for (int i = 0; i < 8; i++) digest_expected.push_back('{chain_words[i], i == 7});
        messages_sent++;
        restart_hash();
    endfunction

    // Sends one beat, inserting a random gap between bursts.
    task automatic send_word(input logic [31:0] wd, input logic [2:0] nbytes, input logic lst);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= wd;
        s_tuser  <= nbytes;
        s_tlast  <= lst;
        do @(posedge aclk); while (!s_tready);
        words_sent++;
        predict_digest(wd, nbytes, lst);
    endtask

    task automatic send_message(input int unsigned nwords, input logic [2:0] last_bytes);
        logic [31:0] wd;
        for (int i = 0; i < nwords; i++) begin
            case ($urandom_range(0, 7))
                0:       wd = '0;
                1:       wd = '1;
                default: wd = $urandom;
            endcase
            // The byte count of a word that is not last must be ignored.
            send_word(wd, 3'($urandom_range(0, 7)), 1'b0);
        end
        wd = ($urandom_range(0, 5) == 0) ? '1 : $urandom;
        send_word(wd, last_bytes, 1'b1);
    endtask

    task automatic test_partial_last_word();
        // One-word messages, from the empty message up to a full word.
        for (int n = 0; n <= 4; n++) send_word(32'hffffffff, 3'(n), 1'b1);
        // Byte counts above four behave as four.
        send_word(32'h00000000, 3'd5, 1'b1);
        send_word(32'ha5c3_5a3c, 3'd6, 1'b1);
        send_word(32'hffffffff, 3'd7, 1'b1);
    endtask

    task automatic test_short_inner_word();
        send_word(32'h61626364, 3'd1, 1'b0);
        send_word(32'h65666768, 3'd4, 1'b1);
    endtask

    task automatic test_padding_extra_block();
        for (int i = 0; i < 14; i++) send_word((i % 2) ? 32'hffffffff : 32'h0, 3'd0, 1'b0);
        send_word(32'hdeadbeef, 3'd2, 1'b1);
    endtask

    task automatic test_random_messages();
        int unsigned stop_at;
        int unsigned nwords;
        stop_at = words_sent + RANDOM_WORDS;
        while (words_sent < stop_at) begin
            case ($urandom_range(0, 9))
                0:          nwords = 0;
                1, 2, 3:    nwords = $urandom_range(12, 17);
                4, 5, 6:    nwords = $urandom_range(1, 11);
                7, 8:       nwords = $urandom_range(18, 33);
                default:    nwords = $urandom_range(28, 47);
            endcase
            send_message(nwords, 3'($urandom_range(0, 7)));
        end
    endtask

    initial begin
        restart_hash();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        test_partial_last_word();
        test_short_inner_word();
        test_padding_extra_block();
        test_random_messages();
        s_tvalid <= 1'b0;
        while (digest_expected.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Hashed %0d messages from %0d input words, %0d needed an extra length block.",
                 messages_sent, words_sent, extra_blocks);
        $display("Checked %0d digest words with random gaps on both channels.", digests_seen);
        if (error_count == 0 && digest_expected.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // The receiver switches between always ready, coin flips, long stalls
    // and a fixed toggle.
    always @(posedge aclk) begin
        if (ready_left == 0) begin
            ready_mode = $urandom_range(0, 3);
            ready_left = $urandom_range(5, 60);
        end
        ready_left--;
        ready_phase++;
        case (ready_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            2:       m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= ready_phase[0];
        endcase
    end

    always @(posedge aclk) begin
        digest_beat_t exp_beat;
        if (aresetn && m_tvalid && m_tready) begin
            digests_seen++;
            if (digest_expected.size() == 0) begin
                $error("unexpected digest beat: digest_word %h digest_last %b",
                       m_tdata, m_tlast);
                error_count++;
            end else begin
                exp_beat = digest_expected.pop_front();
                if (m_tdata !== exp_beat.word) begin
                    $error("digest_word expected %h actual %h", exp_beat.word, m_tdata);
                    error_count++;
                end
                if (m_tlast !== exp_beat.last) begin
                    $error("digest_last expected %b actual %b", exp_beat.last, m_tlast);
                    error_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Timeout: no beat accepted for %0d cycles.", STALL_LIMIT);
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
